// File: src/sha1_stream_hasher_assert.svh
// Assertion macros shared by the hasher's checker.
// Needs nothing else; take in by `include inside a module body.
`ifndef SHA1_STREAM_HASHER_ASSERT_SVH
`define SHA1_STREAM_HASHER_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define SHA1SH_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define SHA1SH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/sha1sh_pkg.sv
// Package for the SHA-1 stream hasher: codes, constants, round functions
// and the control structs passed between the sequencer and its units.
package sha1sh_pkg;

  // Input word modes
  localparam logic [1:0] ModeStart  = 2'd0;
  localparam logic [1:0] ModeByte   = 2'd1;
  localparam logic [1:0] ModeFinish = 2'd2;

  localparam logic [4:0][31:0] ShaIv = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam logic [7:0] PadMarker  = 8'h80;
  localparam logic [5:0] PadLenPos  = 6'd56;
  localparam logic [5:0] LastFill   = 6'd63;
  localparam logic [3:0] LenBytes   = 4'd8;
  localparam logic [6:0] LastRound  = 7'd79;
  localparam logic [6:0] ExpandFrom = 7'd16;
  localparam logic [6:0] Phase1From = 7'd20;
  localparam logic [6:0] Phase2From = 7'd40;
  localparam logic [6:0] Phase3From = 7'd60;
  localparam logic [2:0] DigestWords = 3'd5;

  typedef enum logic [1:0] {
    PhChoose = 2'd0,
    PhParity = 2'd1,
    PhMajor  = 2'd2,
    PhParity2 = 2'd3
  } sha_phase_e;

  typedef struct packed {
    logic       push;       // append one byte
    logic [7:0] data;
    logic       word_done;  // byte completes a 32-bit word
    logic       step;       // advance the schedule by one round
    logic       expand;     // round 16 onwards
  } sha_sched_ctrl_t;

  typedef struct packed {
    logic       init_iv;
    logic       load;
    logic       step;
    sha_phase_e phase;
    logic       accum;
  } sha_cmp_ctrl_t;

  function automatic logic [31:0] round_k(sha_phase_e ph);
    logic [31:0] k;
    case (ph)
      PhChoose: k = 32'h5A827999;
      PhParity: k = 32'h6ED9EBA1;
      PhMajor:  k = 32'h8F1BBCDC;
      default:  k = 32'hCA62C1D6;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] round_f(sha_phase_e ph, logic [31:0] b,
                                          logic [31:0] c, logic [31:0] d);
    logic [31:0] f;
    case (ph)
      PhChoose: f = (b & c) | (~b & d);
      PhMajor:  f = (b & c) | (b & d) | (c & d);
      default:  f = b ^ c ^ d;
    endcase
    return f;
  endfunction

endpackage

// File: src/sha1sh_if.sv
// Valid/ready channel interfaces of the SHA-1 stream hasher.
// Self-contained; no package needed.
interface sha1sh_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] data_byte;

  modport source (output valid, mode, data_byte, input ready);
  modport sink   (input valid, mode, data_byte, output ready);
endinterface

interface sha1sh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last;

  modport source (output valid, digest_word, word_index, last, input ready);
  modport sink   (input valid, digest_word, word_index, last, output ready);
endinterface

// File: src/sha1sh_sched.sv
// Block buffer and rolling 16-word message schedule.
// Depends on sha1sh_pkg.
module sha1sh_sched (
  input  logic                        clk_i,
  input  sha1sh_pkg::sha_sched_ctrl_t ctrl_i,
  output logic [31:0]                 wt_o
);
  import sha1sh_pkg::*;

  logic [23:0]       acc_q;
  logic [15:0][31:0] win_q, win_d;
  logic [31:0]       full_word, mix, expd, wt, shift_in;
  logic              shift_en;

  // From round 16 on, the window holds w[t-16] at index 0 up to w[t-1] at index 15.
  always_comb begin
    full_word = {acc_q, ctrl_i.data};
    mix       = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
    expd      = {mix[30:0], mix[31]};
    wt        = ctrl_i.expand ? expd : win_q[0];
    shift_en  = (ctrl_i.push && ctrl_i.word_done) || ctrl_i.step;
    shift_in  = ctrl_i.step ? wt : full_word;
    win_d     = win_q;
    if (shift_en) begin
      for (int i = 0; i < 15; i++) begin
        win_d[i] = win_q[i + 1];
      end
      win_d[15] = shift_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      acc_q <= full_word[23:0];
    end
    win_q <= win_d;
  end

  assign wt_o = wt;

endmodule

// File: src/sha1sh_compress.sv
// Shared SHA-1 round unit: working words, chaining words, final add.
// Depends on sha1sh_pkg.
module sha1sh_compress (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sha1sh_pkg::sha_cmp_ctrl_t ctrl_i,
  input  logic [31:0]               wt_i,
  output logic [4:0][31:0]          chain_o
);
  import sha1sh_pkg::*;

  logic [4:0][31:0] chain_q, chain_d;
  logic [4:0][31:0] work_q, work_d;
  logic [31:0]      temp;

  // work index 0..4 is a..e
  always_comb begin
    temp = {work_q[0][26:0], work_q[0][31:27]}
         + round_f(ctrl_i.phase, work_q[1], work_q[2], work_q[3])
         + work_q[4] + round_k(ctrl_i.phase) + wt_i;
    work_d = work_q;
    if (ctrl_i.load) begin
      work_d = chain_q;
    end else if (ctrl_i.step) begin
      work_d[0] = temp;
      work_d[1] = work_q[0];
      work_d[2] = {work_q[1][1:0], work_q[1][31:2]};
      work_d[3] = work_q[2];
      work_d[4] = work_q[3];
    end
    chain_d = chain_q;
    if (ctrl_i.init_iv) begin
      chain_d = ShaIv;
    end else if (ctrl_i.accum) begin
      for (int i = 0; i < 5; i++) begin
        chain_d[i] = chain_q[i] + work_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= ShaIv;
    end else begin
      chain_q <= chain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
  end

  assign chain_o = chain_q;

endmodule

// File: src/sha1_stream_hasher.sv
// SHA-1 stream hasher, one byte per word in, five digest words out.
// Start and data words are taken while idle; a data word that fills the
// block closes the input for the 80 rounds and the chaining add.
// Finish pads one byte a cycle (9 to 72), then runs one or two compressions
// and loads the digest, waiting while a previous digest still drains.
// Reset: initial chaining words, counters cleared, no digest pending.
module sha1_stream_hasher (
  input  logic         clk_i,
  input  logic         rst_ni,
  sha1sh_in_if.sink    in_i,
  sha1sh_out_if.source out_o
);
  import sha1sh_pkg::*;

  // One-hot sequencer states
  typedef enum logic [4:0] {
    StIdle  = 5'b00001,  // take input words
    StPad   = 5'b00010,  // append padding and length bytes
    StRound = 5'b00100,  // one compression round per cycle
    StAdd   = 5'b01000,  // fold working words into chaining words
    StDone  = 5'b10000   // hand digest to the output buffer
  } sha_state_e;

  sha_state_e       state_q, state_d;
  logic [5:0]       fill_q, fill_d;      // bytes held in the block
  logic [54:0]      blocks_q, blocks_d;  // blocks compressed, wraps
  logic [6:0]       round_q, round_d;
  logic             fin_q, fin_d;        // finish sequence running
  logic             mark_q, mark_d;      // 0x80 marker still to append
  logic [3:0]       len_cnt_q, len_cnt_d;
  logic [63:0]      len_q, len_d;        // message length in bits
  logic [2:0]       out_cnt_q, out_cnt_d;
  logic [4:0][31:0] out_words_q;
  logic             out_load;

  logic             in_acc, out_acc;
  logic             append_en;
  logic [7:0]       append_byte;
  logic             start;
  logic [4:0][31:0] chain;
  logic [31:0]      wt;
  sha_phase_e       phase;
  sha_sched_ctrl_t  sched_ctrl;
  sha_cmp_ctrl_t    cmp_ctrl;

  assign in_i.ready = (state_q == StIdle);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_acc    = out_o.valid && out_o.ready;

  // Round function group follows the round number
  always_comb begin
    if (round_q < Phase1From) begin
      phase = PhChoose;
    end else if (round_q < Phase2From) begin
      phase = PhParity;
    end else if (round_q < Phase3From) begin
      phase = PhMajor;
    end else begin
      phase = PhParity2;
    end
  end

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    blocks_d    = blocks_q;
    round_d     = round_q;
    fin_d       = fin_q;
    mark_d      = mark_q;
    len_cnt_d   = len_cnt_q;
    len_d       = len_q;
    append_en   = 1'b0;
    append_byte = in_i.data_byte;
    start       = 1'b0;
    out_load    = 1'b0;

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          case (in_i.mode)
            ModeStart: begin
              start = 1'b1;
            end
            ModeByte: begin
              append_en = 1'b1;
            end
            ModeFinish: begin
              // Length is blocks*512 + fill*8; the fields do not overlap.
              fin_d     = 1'b1;
              mark_d    = 1'b1;
              len_cnt_d = '0;
              len_d     = {blocks_q, fill_q, 3'b000};
              state_d   = StPad;
            end
            default: ;  // unused mode: drop the word
          endcase
        end
      end
      StPad: begin
        append_en = 1'b1;
        if (mark_q) begin
          append_byte = PadMarker;
          mark_d      = 1'b0;
        end else if (len_cnt_q == '0 && fill_q != PadLenPos) begin
          append_byte = '0;
        end else begin
          append_byte = len_q[63:56];
          len_d       = {len_q[55:0], 8'h00};
          len_cnt_d   = len_cnt_q + 4'd1;
        end
      end
      StRound: begin
        round_d = round_q + 7'd1;
        if (round_q == LastRound) begin
          state_d = StAdd;
        end
      end
      StAdd: begin
        blocks_d = blocks_q + 55'd1;
        round_d  = '0;
        if (!fin_q) begin
          state_d = StIdle;
        end else if (len_cnt_q == LenBytes) begin
          state_d = StDone;
        end else begin
          state_d = StPad;
        end
      end
      StDone: begin
        // Wait for the previous digest to drain
        if (out_cnt_q == '0) begin
          out_load = 1'b1;
          fin_d    = 1'b0;
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    if (start) begin
      fill_d   = '0;
      blocks_d = '0;
    end
    if (append_en) begin
      fill_d = fill_q + 6'd1;
      if (fill_q == LastFill) begin
        state_d = StRound;  // block full: compress it
        round_d = '0;
      end
    end
  end

  always_comb begin
    sched_ctrl.push      = append_en;
    sched_ctrl.data      = append_byte;
    sched_ctrl.word_done = (fill_q[1:0] == 2'b11);
    sched_ctrl.step      = (state_q == StRound);
    sched_ctrl.expand    = (round_q >= ExpandFrom);

    cmp_ctrl.init_iv = start;
    cmp_ctrl.load    = append_en && (fill_q == LastFill);
    cmp_ctrl.step    = (state_q == StRound);
    cmp_ctrl.phase   = phase;
    cmp_ctrl.accum   = (state_q == StAdd);
  end

  sha1sh_sched u_sched (
    .clk_i  (clk_i),
    .ctrl_i (sched_ctrl),
    .wt_o   (wt)
  );

  sha1sh_compress u_compress (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (cmp_ctrl),
    .wt_i    (wt),
    .chain_o (chain)
  );

  // Output buffer: lets a new message start while the digest drains
  always_comb begin
    out_cnt_d = out_cnt_q;
    if (out_load) begin
      out_cnt_d = DigestWords;
    end else if (out_acc) begin
      out_cnt_d = out_cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_words_q <= chain;
    end else if (out_acc) begin
      out_words_q <= {32'h0, out_words_q[4:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      fill_q    <= '0;
      blocks_q  <= '0;
      round_q   <= '0;
      fin_q     <= 1'b0;
      mark_q    <= 1'b0;
      len_cnt_q <= '0;
      out_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      blocks_q  <= blocks_d;
      round_q   <= round_d;
      fin_q     <= fin_d;
      mark_q    <= mark_d;
      len_cnt_q <= len_cnt_d;
      out_cnt_q <= out_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q <= len_d;
  end

  assign out_o.valid       = (out_cnt_q != '0);
  assign out_o.digest_word = out_words_q[0];
  assign out_o.word_index  = DigestWords - out_cnt_q;
  assign out_o.last        = (out_cnt_q == 3'd1);

endmodule

// File: src/sha1sh_checker.sv
// Port-level checker for the SHA-1 stream hasher, bound to the top level.
// Depends on sha1sh_pkg and sha1_stream_hasher_assert.svh.
module sha1sh_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic [1:0]  in_mode_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_word_i,
  input logic [2:0]  out_index_i,
  input logic        out_last_i
);
  import sha1sh_pkg::*;
  `include "sha1_stream_hasher_assert.svh"

  // Digest words come out in order without gaps
  `SHA1SH_ASSERT_NEXT(a_index_advance, clk_i, rst_ni, out_valid_i && out_ready_i && !out_last_i, out_valid_i && out_index_i == $past(out_index_i) + 3'd1, "digest word index did not advance")
  // Last mark sits on the fifth word only
  `SHA1SH_ASSERT_IMP(a_last_mark, clk_i, rst_ni, out_valid_i, out_last_i == (out_index_i == 3'd4), "last mark not on the fifth digest word")
  // Stalled digest word holds
  `SHA1SH_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_word_i) && $stable(out_index_i), "stalled digest word changed")
  // Finish starts padding, so the input closes
  `SHA1SH_ASSERT_NEXT(a_finish_busy, clk_i, rst_ni, in_valid_i && in_ready_i && in_mode_i == ModeFinish, !in_ready_i, "input still open after finish")

endmodule

bind sha1_stream_hasher sha1sh_checker u_sha1sh_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_mode_i   (in_i.mode),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_word_i  (out_o.digest_word),
  .out_index_i (out_o.word_index),
  .out_last_i  (out_o.last)
);
